// ----- design/mstp_pkg.sv -----
// ----------------------------------------------------------------------------
// mstp_pkg: shared types, constants and microprogram
// Control word layout, sequencer step labels and the microcode ROM for the
// Prim spanning tree engine.
// ----------------------------------------------------------------------------
package mstp_pkg;

	localparam int W_IDX    = 3;
	localparam int W_WEIGHT = 16;
	localparam int W_COST   = 15;

	localparam logic [W_WEIGHT-1:0] NO_EDGE  = 16'hFFFF;
	localparam logic [W_WEIGHT-1:0] INF_COST = 16'hFFFF;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_CLR   = 4'd0;
	localparam pc_t PC_IDLE  = 4'd1;
	localparam pc_t PC_INIT  = 4'd2;
	localparam pc_t PC_SCAN0 = 4'd3;
	localparam pc_t PC_SCAN  = 4'd4;
	localparam pc_t PC_TAIL  = 4'd5;
	localparam pc_t PC_CHECK = 4'd6;
	localparam pc_t PC_RELAX = 4'd7;
	localparam pc_t PC_NEXT  = 4'd8;
	localparam pc_t PC_OUT0  = 4'd9;
	localparam pc_t PC_ORD   = 4'd10;
	localparam pc_t PC_OLD   = 4'd11;
	localparam pc_t PC_DONE  = 4'd12;

	// jump taken when the condition holds, otherwise fall through
	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_CLR_BUSY,
		COND_NO_START,
		COND_VTX_MORE,
		COND_NONE_FOUND,
		COND_STEPS_LEFT,
		COND_OUT_HELD
	} cond_e;

	typedef struct packed {
		logic clr_edge;
		logic accept;
		logic cnt_clr;
		logic cnt_inc;
		logic key_init;
		logic step_clr;
		logic step_inc;
		logic scan_rd;
		logic best_clr;
		logic mark;
		logic rlx_rd;
		logic out_ld;
	} ctrl_t;

	typedef struct packed {
		logic clr_busy;
		logic start;
		logic vtx_more;
		logic none_found;
		logic steps_left;
		logic out_held;
	} stat_t;

	typedef struct packed {
		cond_e cond;
		pc_t   target;
		ctrl_t ctrl;
	} uword_t;

	function automatic uword_t ucode(pc_t pc);
		uword_t w;
		w.cond   = COND_ALWAYS;
		w.target = PC_IDLE;
		w.ctrl   = '0;
		case (pc)
			PC_CLR: begin
				w.cond = COND_CLR_BUSY; w.target = PC_CLR;
				w.ctrl.clr_edge = 1'b1; w.ctrl.cnt_inc = 1'b1;
			end
			PC_IDLE: begin
				w.cond = COND_NO_START; w.target = PC_IDLE;
				w.ctrl.accept = 1'b1; w.ctrl.cnt_clr = 1'b1; w.ctrl.step_clr = 1'b1;
			end
			PC_INIT: begin
				w.cond = COND_VTX_MORE; w.target = PC_INIT;
				w.ctrl.key_init = 1'b1; w.ctrl.cnt_inc = 1'b1;
			end
			PC_SCAN0: begin
				w.cond = COND_NEXT; w.target = PC_SCAN0;
				w.ctrl.cnt_clr = 1'b1; w.ctrl.best_clr = 1'b1;
			end
			PC_SCAN: begin
				w.cond = COND_VTX_MORE; w.target = PC_SCAN;
				w.ctrl.scan_rd = 1'b1; w.ctrl.cnt_inc = 1'b1;
			end
			PC_TAIL: begin
				w.cond = COND_NEXT; w.target = PC_TAIL;
				w.ctrl.cnt_clr = 1'b1;
			end
			PC_CHECK: begin
				w.cond = COND_NONE_FOUND; w.target = PC_OUT0;
				w.ctrl.mark = 1'b1;
			end
			PC_RELAX: begin
				w.cond = COND_VTX_MORE; w.target = PC_RELAX;
				w.ctrl.rlx_rd = 1'b1; w.ctrl.cnt_inc = 1'b1;
			end
			PC_NEXT: begin
				w.cond = COND_STEPS_LEFT; w.target = PC_SCAN0;
				w.ctrl.step_inc = 1'b1;
			end
			PC_OUT0: begin
				w.cond = COND_NEXT; w.target = PC_OUT0;
				w.ctrl.cnt_clr = 1'b1;
			end
			PC_ORD: begin
				w.cond = COND_OUT_HELD; w.target = PC_ORD;
			end
			PC_OLD: begin
				w.cond = COND_VTX_MORE; w.target = PC_ORD;
				w.ctrl.out_ld = 1'b1; w.ctrl.cnt_inc = 1'b1;
			end
			PC_DONE: begin
				w.cond = COND_ALWAYS; w.target = PC_IDLE;
			end
			default: begin
				w.cond = COND_ALWAYS; w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- design/mstp_ram.sv -----
// ----------------------------------------------------------------------------
// mstp_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mstp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/mstp_seq.sv -----
// ----------------------------------------------------------------------------
// mstp_seq: microcode sequencer
// Step counter over the control ROM with conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module mstp_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  mstp_pkg::stat_t stat,
	output mstp_pkg::ctrl_t ctrl
);
	import mstp_pkg::*;

	pc_t    pc_q;
	uword_t uw;
	logic   take;

	assign uw   = ucode(pc_q);
	assign ctrl = uw.ctrl;

	always_comb begin
		case (uw.cond)
			COND_NEXT:       take = 1'b0;
			COND_ALWAYS:     take = 1'b1;
			COND_CLR_BUSY:   take = stat.clr_busy;
			COND_NO_START:   take = !stat.start;
			COND_VTX_MORE:   take = stat.vtx_more;
			COND_NONE_FOUND: take = stat.none_found;
			COND_STEPS_LEFT: take = stat.steps_left;
			COND_OUT_HELD:   take = stat.out_held;
			default:         take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_CLR;
		end else begin
			pc_q <= take ? uw.target : pc_q + 1'b1;
		end
	end

	// program counter stays inside the microprogram
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_DONE)
		else $error("sequencer left the microprogram");

	// the clearing sweep only ever hands over to idle
	a_clr_exit: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == PC_CLR |=> (pc_q == PC_CLR || pc_q == PC_IDLE))
		else $error("clear sweep exited to a wrong step");

endmodule

// ----- design/mstp_dp.sv -----
// ----------------------------------------------------------------------------
// mstp_dp: Prim datapath
// Edge store and key store, index counter, minimum tracker, relax compare
// and the output word register.
// ----------------------------------------------------------------------------
module mstp_dp #(
	parameter int VERTICES = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mstp_pkg::ctrl_t                      ctrl,
	output mstp_pkg::stat_t                      stat,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mstp_pkg::W_IDX-1:0]           row,
	input  logic [mstp_pkg::W_IDX-1:0]           col,
	input  logic signed [mstp_pkg::W_WEIGHT-1:0] weight,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mstp_pkg::W_IDX-1:0]           vertex,
	output logic [mstp_pkg::W_IDX-1:0]           parent,
	output logic [mstp_pkg::W_COST-1:0]          edge_cost,
	output logic                                 has_parent,
	output logic                                 end_of_tree
);
	import mstp_pkg::*;

	localparam int VW     = $clog2(VERTICES);
	localparam int AW     = 2 * VW;
	localparam int EDEPTH = 1 << AW;
	localparam int KDEPTH = 1 << VW;
	localparam int KW     = W_WEIGHT + VW;
	localparam logic [VW-1:0] VLAST = VW'(VERTICES - 1);
	localparam logic [VW-1:0] SLAST = VW'(VERTICES - 2);

	logic [AW-1:0]       cnt_q;
	logic [VW-1:0]       vtx;
	logic [VW-1:0]       step_q;
	logic [VW-1:0]       u_q;
	logic [VW-1:0]       idx_s1;
	logic                scan_s1;
	logic                rlx_s1;
	logic [W_WEIGHT-1:0] best_q;
	logic [VW-1:0]       best_idx_q;
	logic                found_q;
	logic [VERTICES-1:0] in_tree_q;

	logic                out_valid_q;
	logic [W_IDX-1:0]    vertex_q;
	logic [W_IDX-1:0]    parent_q;
	logic [W_COST-1:0]   cost_q;
	logic                hp_q;
	logic                eot_q;

	logic                e_we;
	logic [AW-1:0]       e_waddr;
	logic [W_WEIGHT-1:0] e_wdata;
	logic [W_WEIGHT-1:0] e_rdata;
	logic                k_we;
	logic [VW-1:0]       k_waddr;
	logic [KW-1:0]       k_wdata;
	logic [KW-1:0]       k_rdata;
	logic [W_WEIGHT-1:0] k_cost;
	logic [VW-1:0]       k_par;

	logic [VW+2:0]       row_x;
	logic [VW+2:0]       col_x;
	logic [VW+2:0]       vtx_x;
	logic [VW+2:0]       par_x;
	logic                load_ok;
	logic                relax_upd;
	logic                scan_better;
	logic                hp;

	assign vtx    = cnt_q[VW-1:0];
	assign k_cost = k_rdata[KW-1:VW];
	assign k_par  = k_rdata[VW-1:0];
	assign row_x  = {VW'(0), row};
	assign col_x  = {VW'(0), col};
	assign vtx_x  = {3'b000, vtx};
	assign par_x  = {3'b000, k_par};

	assign in_stall = !ctrl.accept;
	assign load_ok  = in_valid && ctrl.accept
		&& (row_x < (VW + 3)'(VERTICES)) && (col_x < (VW + 3)'(VERTICES));

	// edge store: clear sweep or load word
	assign e_we    = ctrl.clr_edge || load_ok;
	assign e_waddr = ctrl.clr_edge ? cnt_q : {row_x[VW-1:0], col_x[VW-1:0]};
	assign e_wdata = ctrl.clr_edge ? NO_EDGE : $unsigned(weight);

	// sign bit set counts as no edge
	assign relax_upd   = rlx_s1 && !e_rdata[W_WEIGHT-1] && !in_tree_q[idx_s1]
		&& (e_rdata < k_cost);
	assign scan_better = scan_s1 && !in_tree_q[idx_s1] && (k_cost < best_q);

	assign k_we    = ctrl.key_init || relax_upd;
	assign k_waddr = ctrl.key_init ? vtx : idx_s1;
	assign k_wdata = ctrl.key_init ? {((vtx == '0) ? '0 : INF_COST), VW'(0)}
		: {e_rdata, u_q};

	// root never gets a parent; any finite key came from a tree edge
	assign hp = (vtx != '0) && (k_cost != INF_COST);

	mstp_ram #(
		.WIDTH (W_WEIGHT),
		.DEPTH (EDEPTH)
	) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr ({u_q, vtx}),
		.rdata (e_rdata)
	);

	mstp_ram #(
		.WIDTH (KW),
		.DEPTH (KDEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (k_waddr),
		.wdata (k_wdata),
		.raddr (vtx),
		.rdata (k_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			step_q      <= '0;
			scan_s1     <= 1'b0;
			rlx_s1      <= 1'b0;
			found_q     <= 1'b0;
			in_tree_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.cnt_clr) begin
				cnt_q <= '0;
			end else if (ctrl.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctrl.step_clr) begin
				step_q <= '0;
			end else if (ctrl.step_inc) begin
				step_q <= step_q + 1'b1;
			end
			scan_s1 <= ctrl.scan_rd;
			rlx_s1  <= ctrl.rlx_rd;
			if (ctrl.best_clr) begin
				found_q <= 1'b0;
			end else if (scan_better) begin
				found_q <= 1'b1;
			end
			if (ctrl.key_init) begin
				in_tree_q <= '0;
			end else if (ctrl.mark && found_q) begin
				in_tree_q[best_idx_q] <= 1'b1;
			end
			if (ctrl.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= vtx;
		if (ctrl.best_clr) begin
			best_q <= INF_COST;
		end else if (scan_better) begin
			best_q     <= k_cost;
			best_idx_q <= idx_s1;
		end
		if (ctrl.mark && found_q) begin
			u_q <= best_idx_q;
		end
		if (ctrl.out_ld) begin
			vertex_q <= vtx_x[W_IDX-1:0];
			parent_q <= hp ? par_x[W_IDX-1:0] : '0;
			cost_q   <= hp ? k_cost[W_COST-1:0] : '0;
			hp_q     <= hp;
			eot_q    <= (vtx == VLAST);
		end
	end

	assign stat.clr_busy   = (cnt_q != '1);
	assign stat.start      = in_valid && last;
	assign stat.vtx_more   = (vtx != VLAST);
	assign stat.none_found = !found_q;
	assign stat.steps_left = (step_q != SLAST);
	assign stat.out_held   = out_valid_q && out_stall;

	assign out_valid   = out_valid_q;
	assign vertex      = vertex_q;
	assign parent      = parent_q;
	assign edge_cost   = cost_q;
	assign has_parent  = hp_q;
	assign end_of_tree = eot_q;

	// a selected vertex always carries a finite key
	a_found_finite: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> best_q != INF_COST)
		else $error("minimum tracker holds an infinite key");

	// the row being relaxed belongs to a vertex already in the tree
	a_relax_row: assert property (@(posedge clk) disable iff (!arst_n)
		rlx_s1 |-> in_tree_q[u_q])
		else $error("relaxing from a vertex outside the tree");

endmodule

// ----- design/minimum_spanning_tree_prim_core.sv -----
// ----------------------------------------------------------------------------
// minimum_spanning_tree_prim_core: Prim spanning tree over an adjacency matrix
// Top level: microcode sequencer driving the Prim datapath.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one matrix word per unstalled
// cycle: row, col, weight (negative = no edge). Words outside VERTICES are
// dropped. A word with last set is stored, then starts the solve at vertex 0.
// Output channel (out_valid/out_stall) returns one word per vertex in
// increasing order: parent and edge cost, has_parent low for the root and
// unreachable vertices, end_of_tree on vertex VERTICES-1.
// After reset the edge store is swept to no-edge, one entry per cycle,
// over its 2**(2*clog2(VERTICES)) entries (64 at eight vertices); in_stall
// stays high. A solve then runs as sequential scan and relax passes over
// the single-read-port key and edge stores; in_stall stays high until the
// last result is loaded. Results leave through the ORD and OLD steps in
// turn; out_stall holds the word and pauses the sequencer. The next words
// may be loaded while the last result still waits.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_prim_core #(
	parameter int VERTICES = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mstp_pkg::W_IDX-1:0]           row,
	input  logic [mstp_pkg::W_IDX-1:0]           col,
	input  logic signed [mstp_pkg::W_WEIGHT-1:0] weight,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mstp_pkg::W_IDX-1:0]           vertex,
	output logic [mstp_pkg::W_IDX-1:0]           parent,
	output logic [mstp_pkg::W_COST-1:0]          edge_cost,
	output logic                                 has_parent,
	output logic                                 end_of_tree
);
	import mstp_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	mstp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	mstp_dp #(
		.VERTICES (VERTICES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.row         (row),
		.col         (col),
		.weight      (weight),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.vertex      (vertex),
		.parent      (parent),
		.edge_cost   (edge_cost),
		.has_parent  (has_parent),
		.end_of_tree (end_of_tree)
	);

endmodule
